// File: src/clip_rectangle_stack_defines.svh
`ifndef CLIP_RECTANGLE_STACK_DEFINES_SVH
`define CLIP_RECTANGLE_STACK_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define CRS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("clip stack check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define CRS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("clip stack check failed");

`endif

// File: src/crs_pkg.sv
`timescale 1ns / 1ps

package crs_pkg;

  localparam int unsigned COORD_W       = 16;
  localparam int unsigned WIN_W         = 15;
  localparam int unsigned ECC_W         = 16;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [ECC_W-1:0] ECC_MAX = {ECC_W{1'b1}};

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // configuration register indexes
  localparam logic REG_WINDOW_WIDTH  = 1'b0;
  localparam logic REG_WINDOW_HEIGHT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } crs_rect_t;

  typedef struct packed {
    logic   cmd;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } crs_cmd_t;

  typedef struct packed {
    coord_t clip_left;
    coord_t clip_top;
    coord_t clip_right;
    coord_t clip_bottom;
    logic   clip_applied;
    logic   all_clipped;
    logic   overflow;
  } crs_res_t;

endpackage

// File: src/clip_rectangle_stack.sv
`timescale 1ns / 1ps
// a command word accepted into the input register gives its result word from the output register
// throughput: one command word per cycle while res_stall is low, no bubbles between pushes and pops
// the stack top sits in flops, the entry below it is prefetched from the stack ram
// reset clears stack depth, empty-clip count, window size and both valid flags
// stack ram contents are not cleared; no clearing pass follows reset

`include "clip_rectangle_stack_defines.svh"

module clip_rectangle_stack #(
  parameter int unsigned STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // command channel
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  crs_pkg::crs_cmd_t         cmd_word,
  // result channel
  output logic                      res_valid,
  input  logic                      res_stall,
  output crs_pkg::crs_res_t         res_word,
  // configuration write port
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [crs_pkg::WIN_W-1:0] cfg_data
);

  import crs_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  // window size registers
  logic [WIN_W-1:0] window_width;
  logic [WIN_W-1:0] window_height;

  // input register stage
  logic     v1;
  crs_cmd_t item1;

  // stack state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [ECC_W-1:0] ecc;
  logic [ECC_W-1:0] ecc_next;
  crs_rect_t        top_rect;
  crs_rect_t        top_next;

  // stack ram: entries 0 .. count-1, top also held in top_rect
  crs_rect_t        mem [STACK_DEPTH];
  crs_rect_t        below;        // registered read of entry count-2
  logic [CNT_W-1:0] rd_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  // handshake
  logic adv;
  logic upd;
  logic cmd_accept;

  // datapath
  crs_rect_t win_rect;
  crs_rect_t cur_rect;
  crs_rect_t isect;
  logic      isect_ok;
  logic      applied_call;
  logic      ovf;
  crs_res_t  res_next;

  // output register frees when empty or when its word is being taken
  assign adv        = !res_valid || !res_stall;
  assign cmd_stall  = v1 && !adv;
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign upd        = v1 && adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= '0;
      window_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_WIDTH:  window_width  <= cfg_data;
        REG_WINDOW_HEIGHT: window_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd_accept || (v1 && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      item1 <= cmd_word;
    end
  end

  // window rectangle is the clip when the stack is empty
  always_comb begin
    win_rect.l = '0;
    win_rect.t = '0;
    win_rect.r = $signed({1'b0, window_width});
    win_rect.b = $signed({1'b0, window_height});
  end

  assign cur_rect = (count == '0) ? win_rect : top_rect;

  // intersect pushed rectangle with current clip
  always_comb begin
    isect.l  = (cur_rect.l > item1.left)   ? cur_rect.l : item1.left;
    isect.t  = (cur_rect.t > item1.top)    ? cur_rect.t : item1.top;
    isect.r  = (cur_rect.r < item1.right)  ? cur_rect.r : item1.right;
    isect.b  = (cur_rect.b < item1.bottom) ? cur_rect.b : item1.bottom;
    isect_ok = (isect.l < isect.r) && (isect.t < isect.b);
  end

  // next stack state for the word in the input register
  always_comb begin
    count_next   = count;
    ecc_next     = ecc;
    top_next     = top_rect;
    applied_call = 1'b0;
    ovf          = 1'b0;
    mem_we       = 1'b0;
    if (upd) begin
      if (item1.cmd == CMD_PUSH) begin
        applied_call = 1'b1;
        if (ecc != '0) begin
          // already fully clipped: only count the nesting, saturating
          if (ecc != ECC_MAX) begin
            ecc_next = ecc + ECC_W'(1);
          end
        end else if (isect_ok) begin
          if (count == DEPTH_CNT) begin
            ovf = 1'b1;
          end else begin
            mem_we     = 1'b1;
            top_next   = isect;
            count_next = count + CNT_W'(1);
          end
        end else begin
          ecc_next = ECC_W'(1);
        end
      end else if (count != '0) begin
        // pop on an empty stack is ignored
        applied_call = 1'b1;
        if (ecc != '0) begin
          ecc_next = ecc - ECC_W'(1);
        end else begin
          count_next = count - CNT_W'(1);
          top_next   = below;
        end
      end
    end
  end

  // prefetch the entry under the new top so a pop in the next cycle finds it
  assign rd_cnt  = count_next - CNT_W'(2);
  assign rd_addr = rd_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= isect;
    end
    below <= mem[rd_addr];
  end

  // stack control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ecc   <= '0;
    end else begin
      count <= count_next;
      ecc   <= ecc_next;
    end
  end

  always_ff @(posedge clk) begin
    top_rect <= top_next;
  end

  // result word reflects the state after the command
  always_comb begin
    res_next.clip_left    = (count_next == '0) ? win_rect.l : top_next.l;
    res_next.clip_top     = (count_next == '0) ? win_rect.t : top_next.t;
    res_next.clip_right   = (count_next == '0) ? win_rect.r : top_next.r;
    res_next.clip_bottom  = (count_next == '0) ? win_rect.b : top_next.b;
    res_next.clip_applied = applied_call && (ecc_next == '0) && (count_next != '0);
    res_next.all_clipped  = (ecc_next != '0);
    res_next.overflow     = ovf;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res_word <= res_next;
    end
  end

  `CRS_ASSERT_NOW(a_count_range, 1'b1, count <= DEPTH_CNT)
  `CRS_ASSERT_NOW(a_ovf_applied, res_valid && res_word.overflow, res_word.clip_applied)
  `CRS_ASSERT_NOW(a_clipped_not_applied, res_valid && res_word.all_clipped,
                  !res_word.clip_applied)
  `CRS_ASSERT_NEXT(a_empty_pop_ignored, upd && item1.cmd == CMD_POP && count == '0,
                   count == '0 && $stable(ecc))

endmodule

// File: verif/clip_rectangle_stack_tb.sv
`timescale 1ns / 1ps

module clip_rectangle_stack_tb;
  import crs_pkg::*;

  // tracks the clip stack and queues the result word each command word should give
  class clip_stack_scoreboard;
    logic [WIN_W-1:0] win_w = '0;
    logic [WIN_W-1:0] win_h = '0;
    crs_rect_t        clips[STACK_DEPTH_DEF];
    int unsigned      depth = 0;
    int unsigned      empty_cnt = 0;
    crs_res_t         pending[$];
    int unsigned      errors = 0;
    int unsigned      checked = 0;
    int unsigned      overflows = 0;
    int unsigned      peak_cnt = 0;

    // window rect when the stack is empty, else the stack top
    function crs_rect_t cur_clip();
      crs_rect_t w;
      if (depth == 0) begin
        w.l = '0;
        w.t = '0;
        w.r = coord_t'({1'b0, win_w});
        w.b = coord_t'({1'b0, win_h});
        return w;
      end
      return clips[depth-1];
    endfunction

    function void note(crs_cmd_t c);
      crs_res_t  e;
      crs_rect_t p;
      crs_rect_t n;
      logic      applied;
      logic      ovf;
      applied = 1'b0;
      ovf     = 1'b0;
      if (c.cmd == CMD_PUSH) begin
        applied = 1'b1;
        if (empty_cnt != 0) begin
          if (empty_cnt < ECC_MAX) empty_cnt++;
        end else begin
          p   = cur_clip();
          n.l = (p.l > c.left)   ? p.l : c.left;
          n.t = (p.t > c.top)    ? p.t : c.top;
          n.r = (p.r < c.right)  ? p.r : c.right;
          n.b = (p.b < c.bottom) ? p.b : c.bottom;
          if (n.l < n.r && n.t < n.b) begin
            if (depth == STACK_DEPTH_DEF) begin
              ovf = 1'b1;
              overflows++;
            end else begin
              clips[depth] = n;
              depth++;
            end
          end else begin
            empty_cnt = 1;
          end
        end
      end else if (depth != 0) begin
        // pop on an empty stack is ignored, even with the count nonzero
        applied = 1'b1;
        if (empty_cnt != 0) empty_cnt--;
        else depth--;
      end
      if (empty_cnt > peak_cnt) peak_cnt = empty_cnt;
      p              = cur_clip();
      e.clip_left    = p.l;
      e.clip_top     = p.t;
      e.clip_right   = p.r;
      e.clip_bottom  = p.b;
      e.clip_applied = applied && empty_cnt == 0 && depth != 0;
      e.all_clipped  = empty_cnt != 0;
      e.overflow     = ovf;
      pending.push_back(e);
    endfunction

    function void field(string name, logic signed [16:0] e, logic signed [16:0] a);
      if (a !== e) begin
        $error("%s expected %0d got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check(crs_res_t r);
      crs_res_t e;
      if (pending.size() == 0) begin
        $error("result word with no command word pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      field("clip_left", e.clip_left, r.clip_left);
      field("clip_top", e.clip_top, r.clip_top);
      field("clip_right", e.clip_right, r.clip_right);
      field("clip_bottom", e.clip_bottom, r.clip_bottom);
      field("clip_applied", e.clip_applied, r.clip_applied);
      field("all_clipped", e.all_clipped, r.all_clipped);
      field("overflow", e.overflow, r.overflow);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cmd_valid;
  logic             cmd_stall;
  crs_cmd_t         cmd_word;
  logic             res_valid;
  logic             res_stall = 1'b0;
  crs_res_t         res_word;
  logic             cfg_we;
  logic             cfg_index;
  logic [WIN_W-1:0] cfg_data;

  clip_stack_scoreboard sb;

  // idle rates in percent, and the long receiver hold-off request
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned push_bias = 50;
  int unsigned n_sent    = 0;

  clip_rectangle_stack DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off counted here once requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check(res_word);
  end

  // generous cap on the whole run
  initial begin
    #5_000_000;
    $display("clip_rectangle_stack verification failed");
    $finish;
  end

  function automatic coord_t clamp16(int v);
    if (v < -32768) return coord_t'(-32768);
    if (v > 32767) return coord_t'(32767);
    return coord_t'(v);
  endfunction

  // offer one command word at a falling edge, hold it until taken
  task automatic send_word(crs_cmd_t w);
    while ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note(w);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic push_rect(int l, int t, int r, int b);
    crs_cmd_t w;
    w.cmd    = CMD_PUSH;
    w.left   = clamp16(l);
    w.top    = clamp16(t);
    w.right  = clamp16(r);
    w.bottom = clamp16(b);
    send_word(w);
  endtask

  // edges of a pop carry noise, the block ignores them
  task automatic pop_word();
    crs_cmd_t w;
    w     = crs_cmd_t'({$urandom, $urandom, $urandom});
    w.cmd = CMD_POP;
    send_word(w);
  endtask

  task automatic pop_to_empty();
    while (sb.depth != 0) pop_word();
  endtask

  // stop offering, let every expected word come back, then a short tail
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // writes both window registers back to back; call only while idle
  task automatic set_window(logic [WIN_W-1:0] w, logic [WIN_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_WINDOW_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.win_w = w;
    sb.win_h = h;
  endtask

  // mostly pushes nested inside the current clip; some noise pushes once
  // the stack holds an entry, so the empty-clip count gets exercised too.
  // with the stack empty and nothing clipped away only nested pushes go
  // out, because an empty push there would lock the count on for good
  function automatic crs_cmd_t make_word();
    crs_cmd_t  w;
    crs_rect_t c;
    int        x1;
    int        x2;
    int        y1;
    int        y2;
    w = crs_cmd_t'({$urandom, $urandom, $urandom});
    w.cmd = ($urandom_range(99) < push_bias) ? CMD_PUSH : CMD_POP;
    if (w.cmd == CMD_PUSH && sb.empty_cnt == 0 &&
        (sb.depth == 0 || $urandom_range(99) >= 15)) begin
      c  = sb.cur_clip();
      x1 = int'(c.l) + $urandom_range(0, (int'(c.r) - int'(c.l) - 1) / 3);
      x2 = int'(c.r) - $urandom_range(0, (int'(c.r) - x1 - 1) / 3);
      y1 = int'(c.t) + $urandom_range(0, (int'(c.b) - int'(c.t) - 1) / 3);
      y2 = int'(c.b) - $urandom_range(0, (int'(c.b) - y1 - 1) / 3);
      // stretch some edges past the clip, the intersection trims them
      if ($urandom_range(3) == 0) x1 = x1 - int'($urandom_range(0, 40000));
      if ($urandom_range(3) == 0) x2 = x2 + int'($urandom_range(0, 40000));
      if ($urandom_range(3) == 0) y1 = y1 - int'($urandom_range(0, 40000));
      if ($urandom_range(3) == 0) y2 = y2 + int'($urandom_range(0, 40000));
      w.left   = clamp16(x1);
      w.right  = clamp16(x2);
      w.top    = clamp16(y1);
      w.bottom = clamp16(y2);
    end
    return w;
  endfunction

  task automatic run_random(int unsigned n, int unsigned s_idle, int unsigned r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int unsigned i = 0; i < n; i++) begin
      // shift the push/pop mix now and then so the stack fills and drains
      if (i % 50 == 0) push_bias = $urandom_range(25, 85);
      send_word(make_word());
    end
  endtask

  initial begin
    crs_cmd_t w;
    sb        = new();
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_word  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_WINDOW_WIDTH;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words in a 640x480 window, no idling
    set_window(15'd640, 15'd480);
    pop_word();                                 // pop with nothing stacked
    push_rect(-32768, -32768, 32767, 32767);    // widest rect collapses to window
    push_rect(300, 10, 300, 400);               // zero width, clipped away
    push_rect(0, 0, 10, 10);                    // push while clipped away
    pop_word();
    pop_word();                                 // count back to zero, top reapplied
    push_rect(640, 0, 700, 480);                // only touches the clip edge
    pop_word();
    for (int i = 0; i < 16; i++) push_rect(i, i, 600 - i, 400 - i);  // last one overflows
    push_rect(30, 40, 20, 50);                  // left past right on a full stack
    pop_word();
    push_rect(20, 60, 40, 60);                  // top equal to bottom
    pop_word();
    pop_to_empty();
    wait_idle();

    // random phases: sender idles less than receiver, then swapped
    set_window(15'($urandom_range(1, 400)), 15'($urandom_range(1, 400)));
    run_random(380, 32, 46);
    wait_idle();
    set_window(15'd32767, 15'd32767);
    run_random(380, 46, 32);
    wait_idle();

    // no idling; receiver holds off long enough to back the block up
    set_window(15'd1, 15'd32767);
    hold_req = 1'b1;
    run_random(220, 0, 0);
    wait_idle();                                // sender pause until all words are back
    run_random(180, 0, 0);
    pop_to_empty();
    wait_idle();

    // zero window: any push on the empty stack is clipped away, pops are
    // then ignored, and a run of pushes keeps raising the count
    set_window('0, '0);
    pop_word();
    push_rect(-10, -10, 10, 10);
    pop_word();                                 // ignored although the count is set
    w.cmd = CMD_PUSH;
    repeat (100) begin
      w.left   = coord_t'($urandom);
      w.top    = coord_t'($urandom);
      w.right  = coord_t'($urandom);
      w.bottom = coord_t'($urandom);
      send_word(w);
    end
    pop_word();
    wait_idle();

    $display("sent %0d command words, checked %0d result words", n_sent, sb.checked);
    $display("saw %0d full-stack drops, empty-clip count peaked at %0d",
             sb.overflows, sb.peak_cnt);
    if (sb.errors == 0) begin
      $display("clip_rectangle_stack verification clean");
    end else begin
      $display("clip_rectangle_stack verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/crs_pkg.sv
src/clip_rectangle_stack.sv
verif/clip_rectangle_stack_tb.sv
